@@ rtl/core/tsdf_pkg.sv @@
// Shared types, codes and sizes for the typed snapshot diff filter.
`timescale 1ns / 1ps

package tsdf_pkg;

   // Default width of the running byte offset
   localparam int OffsetBitsDefault = 32;

   // Element queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Configuration port
   localparam int CsrAddrW = 6;
   localparam int CsrDataW = 64;
   localparam int CsrIdxW  = 3;

   typedef enum logic [CsrIdxW-1:0] {
      REG_FILTER_MODE = 3'd0,
      REG_DATA_TYPE   = 3'd1,
      REG_VALUE_A     = 3'd2,
      REG_VALUE_B     = 3'd3,
      REG_MASK_BITS   = 3'd4,
      REG_MASK_TARGET = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      FLT_CHANGED    = 4'd0,
      FLT_UNCHANGED  = 4'd1,
      FLT_INCREASED  = 4'd2,
      FLT_DECREASED  = 4'd3,
      FLT_INCR_BY    = 4'd4,
      FLT_DECR_BY    = 4'd5,
      FLT_EXACT      = 4'd6,
      FLT_RANGE      = 4'd7,
      FLT_BITMASK    = 4'd8,
      FLT_STABILIZED = 4'd9
   } filter_mode_type;

   typedef enum logic [2:0] {
      DT_BYTES  = 3'd0,
      DT_INT8   = 3'd1,
      DT_UINT8  = 3'd2,
      DT_INT16  = 3'd3,
      DT_UINT16 = 3'd4,
      DT_INT32  = 3'd5,
      DT_UINT32 = 3'd6,
      DT_FLOAT  = 3'd7
   } data_type_type;

   // Configuration register set
   typedef struct packed {
      logic [3:0]  filter_mode;
      logic [2:0]  data_type;
      logic [63:0] value_a;
      logic [63:0] value_b;
      logic [31:0] mask_bits;
      logic [31:0] mask_target;
   } cfg_type;

   // One gathered element candidate on its way to the filter
   typedef struct packed {
      logic        is_bytes;
      logic [31:0] offset;
      logic [31:0] old_raw;
      logic [31:0] new_raw;
   } elem_type;

endpackage

@@ rtl/core/tsdf_front.sv @@
// Front end: tracks the byte offset and gathers bytes into element candidates.
`timescale 1ns / 1ps

module tsdf_front #(
   parameter int OFFSET_BITS = tsdf_pkg::OffsetBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          data_type,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          before_byte,
   input  logic [7:0]          after_byte,
   input  logic                end_of_region,
   output logic                push_valid,
   input  logic                push_ready,
   output tsdf_pkg::elem_type  push_elem
);

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [1:0]             lane_ff, lane_in;
   logic [23:0]            old_asm_ff, old_asm_in;
   logic [23:0]            new_asm_ff, new_asm_in;

   logic                   accept;
   logic                   is_bytes;
   logic [1:0]             top_lane;
   logic                   complete;
   logic [OFFSET_BITS-1:0] elem_off;
   logic [OFFSET_BITS+31:0] pos_ext;
   logic [OFFSET_BITS+31:0] off_ext;
   logic [31:0]            old_raw;
   logic [31:0]            new_raw;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;
   assign is_bytes = (data_type == tsdf_pkg::DT_BYTES);

   // Last lane of the element for the current type
   always_comb begin
      unique case (data_type) inside
         tsdf_pkg::DT_INT16, tsdf_pkg::DT_UINT16: top_lane = 2'd1;
         tsdf_pkg::DT_INT32, tsdf_pkg::DT_UINT32, tsdf_pkg::DT_FLOAT: top_lane = 2'd3;
         default: top_lane = 2'd0;
      endcase
   end

   assign complete = !is_bytes && (lane_ff >= top_lane);

   // Element start offset, wrapped to the offset width, carried as 32 bits
   assign elem_off = pos_ff - OFFSET_BITS'(lane_ff);
   assign pos_ext  = {32'd0, pos_ff};
   assign off_ext  = {32'd0, elem_off};

   // Place the current byte on top of the gathered lower lanes
   always_comb begin
      unique case (top_lane)
         2'd1: begin
            old_raw = {16'd0, before_byte, old_asm_ff[7:0]};
            new_raw = {16'd0, after_byte, new_asm_ff[7:0]};
         end
         2'd3: begin
            old_raw = {before_byte, old_asm_ff};
            new_raw = {after_byte, new_asm_ff};
         end
         default: begin
            old_raw = {24'd0, before_byte};
            new_raw = {24'd0, after_byte};
         end
      endcase
   end

   // Build the candidate for the queue
   always_comb begin
      push_elem.is_bytes = is_bytes;
      if (is_bytes) begin
         push_elem.offset  = pos_ext[31:0];
         push_elem.old_raw = {24'd0, before_byte};
         push_elem.new_raw = {24'd0, after_byte};
         push_valid        = in_valid && (before_byte != after_byte);
      end else begin
         push_elem.offset  = off_ext[31:0];
         push_elem.old_raw = old_raw;
         push_elem.new_raw = new_raw;
         push_valid        = in_valid && complete;
      end
   end

   // Advance offset, lane and assemblies
   always_comb begin
      pos_in     = pos_ff;
      lane_in    = lane_ff;
      old_asm_in = old_asm_ff;
      new_asm_in = new_asm_ff;
      if (accept) begin
         if (is_bytes || complete) begin
            lane_in    = 2'd0;
            old_asm_in = 24'd0;
            new_asm_in = 24'd0;
         end else begin
            unique case (lane_ff)
               2'd0: begin
                  old_asm_in[7:0] = old_asm_ff[7:0] | before_byte;
                  new_asm_in[7:0] = new_asm_ff[7:0] | after_byte;
               end
               2'd1: begin
                  old_asm_in[15:8] = old_asm_ff[15:8] | before_byte;
                  new_asm_in[15:8] = new_asm_ff[15:8] | after_byte;
               end
               default: begin
                  old_asm_in[23:16] = old_asm_ff[23:16] | before_byte;
                  new_asm_in[23:16] = new_asm_ff[23:16] | after_byte;
               end
            endcase
            lane_in = lane_ff + 2'd1;
         end
         if (end_of_region) begin
            pos_in     = '0;
            lane_in    = 2'd0;
            old_asm_in = 24'd0;
            new_asm_in = 24'd0;
         end else begin
            pos_in = pos_ff + OFFSET_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         lane_ff    <= 2'd0;
         old_asm_ff <= 24'd0;
         new_asm_ff <= 24'd0;
      end else begin
         pos_ff     <= pos_in;
         lane_ff    <= lane_in;
         old_asm_ff <= old_asm_in;
         new_asm_ff <= new_asm_in;
      end
   end

endmodule

@@ rtl/core/tsdf_queue.sv @@
// Short element queue between the front end and the filter back end.
`timescale 1ns / 1ps

module tsdf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tsdf_pkg::elem_type push_elem,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tsdf_pkg::elem_type pop_elem
);

   tsdf_pkg::elem_type store_ff [tsdf_pkg::QueueDepth];

   logic [tsdf_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tsdf_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tsdf_pkg::QueueCntW-1:0] count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign push_ready = (count_ff != tsdf_pkg::QueueCntW'(tsdf_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_elem   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == tsdf_pkg::QueuePtrW'(tsdf_pkg::QueueDepth - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == tsdf_pkg::QueuePtrW'(tsdf_pkg::QueueDepth - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_elem;
      end
   end

endmodule

@@ rtl/core/tsdf_back.sv @@
// Back end: widens element values, applies the filter and holds the result beat.
`timescale 1ns / 1ps

module tsdf_back (
   input  logic               clock,
   input  logic               reset,
   input  tsdf_pkg::cfg_type  cfg,
   input  logic               elem_valid,
   output logic               elem_ready,
   input  tsdf_pkg::elem_type elem,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_offset,
   output logic [63:0]        out_old,
   output logic [63:0]        out_new
);

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_offset_ff;
   logic [63:0] out_old_ff;
   logic [63:0] out_new_ff;

   logic [63:0] old_val;
   logic [63:0] new_val;
   logic [63:0] up_delta;
   logic [63:0] down_delta;
   logic        filter_hit;
   logic        match;
   logic        take;

   // Widen a raw element by type
   function automatic logic [63:0] widen(input logic [31:0] raw, input logic [2:0] dt);
      logic [63:0] val;
      unique case (dt)
         tsdf_pkg::DT_INT8:   val = {{56{raw[7]}}, raw[7:0]};
         tsdf_pkg::DT_UINT8:  val = {56'd0, raw[7:0]};
         tsdf_pkg::DT_INT16:  val = {{48{raw[15]}}, raw[15:0]};
         tsdf_pkg::DT_UINT16: val = {48'd0, raw[15:0]};
         tsdf_pkg::DT_INT32:  val = {{32{raw[31]}}, raw};
         default:             val = {32'd0, raw};
      endcase
      return val;
   endfunction

   assign old_val    = widen(elem.old_raw, cfg.data_type);
   assign new_val    = widen(elem.new_raw, cfg.data_type);
   assign up_delta   = new_val - old_val;
   assign down_delta = old_val - new_val;

   // Filter decode
   always_comb begin
      unique case (cfg.filter_mode) inside
         tsdf_pkg::FLT_CHANGED:    filter_hit = (old_val != new_val);
         tsdf_pkg::FLT_UNCHANGED,
         tsdf_pkg::FLT_STABILIZED: filter_hit = (old_val == new_val);
         tsdf_pkg::FLT_INCREASED:  filter_hit = (new_val > old_val);
         tsdf_pkg::FLT_DECREASED:  filter_hit = (new_val < old_val);
         tsdf_pkg::FLT_INCR_BY:    filter_hit = (up_delta == cfg.value_a);
         tsdf_pkg::FLT_DECR_BY:    filter_hit = (down_delta == cfg.value_a);
         tsdf_pkg::FLT_EXACT:      filter_hit = (new_val == cfg.value_a);
         tsdf_pkg::FLT_RANGE:      filter_hit = (new_val >= cfg.value_a) &&
                                                (new_val <= cfg.value_b);
         tsdf_pkg::FLT_BITMASK:    filter_hit = ((new_val[31:0] & cfg.mask_bits) ==
                                                 cfg.mask_target);
         default:                  filter_hit = 1'b0;
      endcase
   end

   // Byte candidates already differ, so they always report
   assign match      = elem.is_bytes || filter_hit;
   assign take       = elem_valid && (!out_valid_ff || out_ready);
   assign elem_ready = !out_valid_ff || out_ready;

   // Load the output slot on a match, drop non-matching elements
   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      if (take && match) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && match) begin
         out_offset_ff <= elem.offset;
         out_old_ff    <= old_val;
         out_new_ff    <= new_val;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_offset = out_offset_ff;
   assign out_old    = out_old_ff;
   assign out_new    = out_new_ff;

endmodule

@@ rtl/core/typed_snapshot_diff_filter.sv @@
// A result beat is registered in the element queue, then in the back end output slot.
// Throughput: one byte pair per cycle while the queue has room; the front fills one lane
// per byte, and the back evaluates one element per cycle unless stalled, with a single
// 64-bit compare stage. A two-entry element queue lets front and back stall independently.
// Reset clears all configuration registers to zero, the byte offset, lane and assemblies.
`timescale 1ns / 1ps

module typed_snapshot_diff_filter #(
   parameter int OFFSET_BITS = tsdf_pkg::OffsetBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // Byte pair stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // before_byte, after_byte
   input  logic                          req_tlast,   // end_of_region
   // Match stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [159:0]                  rsp_tdata,   // match_offset, old_value, new_value
   // Configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tsdf_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [tsdf_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [tsdf_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);

   tsdf_pkg::cfg_type  cfg_ff, cfg_in;
   tsdf_pkg::elem_type push_elem;
   tsdf_pkg::elem_type pop_elem;

   logic                         csr_write;
   logic [tsdf_pkg::CsrIdxW-1:0] csr_index;
   logic                         push_valid;
   logic                         push_ready;
   logic                         pop_valid;
   logic                         pop_ready;
   logic [31:0]                  out_offset;
   logic [63:0]                  out_old;
   logic [63:0]                  out_new;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[tsdf_pkg::CsrAddrW-1:tsdf_pkg::CsrAddrW-tsdf_pkg::CsrIdxW];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            tsdf_pkg::REG_FILTER_MODE: cfg_in.filter_mode = csr_pwdata[3:0];
            tsdf_pkg::REG_DATA_TYPE:   cfg_in.data_type   = csr_pwdata[2:0];
            tsdf_pkg::REG_VALUE_A:     cfg_in.value_a     = csr_pwdata;
            tsdf_pkg::REG_VALUE_B:     cfg_in.value_b     = csr_pwdata;
            tsdf_pkg::REG_MASK_BITS:   cfg_in.mask_bits   = csr_pwdata[31:0];
            tsdf_pkg::REG_MASK_TARGET: cfg_in.mask_target = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_index)
         tsdf_pkg::REG_FILTER_MODE: csr_prdata = {60'd0, cfg_ff.filter_mode};
         tsdf_pkg::REG_DATA_TYPE:   csr_prdata = {61'd0, cfg_ff.data_type};
         tsdf_pkg::REG_VALUE_A:     csr_prdata = cfg_ff.value_a;
         tsdf_pkg::REG_VALUE_B:     csr_prdata = cfg_ff.value_b;
         tsdf_pkg::REG_MASK_BITS:   csr_prdata = {32'd0, cfg_ff.mask_bits};
         tsdf_pkg::REG_MASK_TARGET: csr_prdata = {32'd0, cfg_ff.mask_target};
         default:                   csr_prdata = '0;
      endcase
   end

   tsdf_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .data_type     (cfg_ff.data_type),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .before_byte   (req_tdata[7:0]),
      .after_byte    (req_tdata[15:8]),
      .end_of_region (req_tlast),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_elem     (push_elem)
   );

   tsdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_elem  (push_elem),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_elem   (pop_elem)
   );

   tsdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .elem_valid (pop_valid),
      .elem_ready (pop_ready),
      .elem       (pop_elem),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_offset (out_offset),
      .out_old    (out_old),
      .out_new    (out_new)
   );

   assign rsp_tdata = {out_new, out_old, out_offset};

endmodule
